>>> hw/rtl/lobm_pkg.sv
package lobm_pkg;

    localparam logic SIDE_ASK = 1'b0;
    localparam logic SIDE_BID = 1'b1;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_DROPPED = 1'b1;

    typedef struct packed {
        logic        is_buy;
        logic [31:0] limit_price;
        logic [31:0] quantity;
    } t_order_in;

    typedef struct packed {
        logic [31:0] order_id;
        logic [31:0] filled_qty;
        logic [31:0] rested_qty;
        logic        status;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
    } t_order_out;

endpackage

>>> hw/rtl/limit_order_book_matcher.sv
// Limit order matcher with price-time priority. An order is taken when start is
// high and busy is low. Busy then stays high while the order is worked. A zero
// quantity goes straight to the finish state. Otherwise each resting entry the
// order trades against takes a check with a read of the level FIFO memory, then
// the trade with its write-back. When a remainder is left, the matcher steps over
// the price levels on its own side that are passed over before the slot is found,
// and places the remainder once the slot is found. The one result beat
// appears on o_result in the first cycle that busy is low again. It is marked by
// o_valid for that single cycle, and the receiver cannot stall, so it must take
// the beat then. Each side keeps its level FIFOs in one memory. The sorted level
// table maps to physical FIFO regions, so inserting or removing a level moves
// only small descriptors.
module limit_order_book_matcher #(
    parameter int MAX_LEVELS       = 16,
    parameter int ORDERS_PER_LEVEL = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  lobm_pkg::t_order_in  i_order,
    output logic                 busy,
    output logic                 o_valid,
    output lobm_pkg::t_order_out o_result
);

    localparam int LW    = MAX_LEVELS > 1 ? $clog2(MAX_LEVELS) : 1;
    localparam int UW    = $clog2(MAX_LEVELS + 1);
    localparam int PW    = ORDERS_PER_LEVEL > 1 ? $clog2(ORDERS_PER_LEVEL) : 1;
    localparam int FW    = $clog2(ORDERS_PER_LEVEL + 1);
    localparam int DEPTH = MAX_LEVELS * ORDERS_PER_LEVEL;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MCHK,
        S_MRD,
        S_SRCH,
        S_FIN
    } t_state;

    t_state      r_state;
    logic        r_buy;
    logic [31:0] r_lim;
    logic [31:0] r_rem;
    logic [31:0] r_filled;
    logic [31:0] r_rested;
    logic        r_status;
    logic [31:0] r_id;
    logic [31:0] r_next_id;
    logic [UW-1:0] r_idx;
    logic        r_valid;
    lobm_pkg::t_order_out r_out;

    logic [31:0]   r_price [2][MAX_LEVELS];
    logic [FW-1:0] r_fill  [2][MAX_LEVELS];
    logic [PW-1:0] r_head  [2][MAX_LEVELS];
    logic [LW-1:0] r_phys  [2][MAX_LEVELS];
    logic [UW-1:0] r_used  [2];

    logic [AW-1:0] raddr [2];
    logic [31:0]   rdata [2];
    logic          we    [2];
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    logic          opp;
    logic          own;
    logic [31:0]   best_p;
    logic          can_match;
    logic [31:0]   q;
    logic [31:0]   take;
    logic          pop;
    logic [LW-1:0] sidx;
    logic [LW-1:0] uidx;
    logic          in_range;
    logic [31:0]   sp;
    logic          eq;
    logic          worse;
    logic          ins;
    logic [FW:0]   tsum;
    logic [PW-1:0] tail;
    logic [LW-1:0] pos;
    logic [PW-1:0] nhead;

    function automatic logic [AW-1:0] qaddr(input logic [LW-1:0] phys,
                                            input logic [PW-1:0] ptr);
        qaddr = AW'(AW'(phys) * AW'(ORDERS_PER_LEVEL)) + AW'(ptr);
    endfunction

    always_comb begin
        opp       = ~r_buy;
        own       = r_buy;
        best_p    = r_price[opp][0];
        can_match = (r_rem != 32'd0) && (r_used[opp] != '0)
                    && (r_buy ? (r_lim >= best_p) : (r_lim <= best_p));
        q         = rdata[opp];
        take      = (q < r_rem) ? q : r_rem;
        pop       = (q == take);
        nhead     = (r_head[opp][0] == PW'(ORDERS_PER_LEVEL - 1)) ? '0
                    : r_head[opp][0] + PW'(1);
        sidx      = r_idx[LW-1:0];
        uidx      = r_used[own][LW-1:0];
        in_range  = r_idx < r_used[own];
        sp        = r_price[own][sidx];
        eq        = in_range && (sp == r_lim);
        worse     = r_buy ? (sp < r_lim) : (sp > r_lim);
        ins       = !eq && (!in_range || worse);
        pos       = in_range ? sidx : uidx;
        tsum      = (FW+1)'(r_head[own][sidx]) + (FW+1)'(r_fill[own][sidx]);
        if (tsum >= (FW+1)'(ORDERS_PER_LEVEL)) begin
            tsum = tsum - (FW+1)'(ORDERS_PER_LEVEL);
        end
        tail      = PW'(tsum);

        raddr[0] = qaddr(r_phys[0][0], r_head[0][0]);
        raddr[1] = qaddr(r_phys[1][0], r_head[1][0]);
        we[0]    = 1'b0;
        we[1]    = 1'b0;
        waddr    = qaddr(r_phys[opp][0], r_head[opp][0]);
        wdata    = q - take;
        case (r_state)
            S_MRD: begin
                we[opp] = !pop;
            end
            S_SRCH: begin
                wdata = r_rem;
                if (eq) begin
                    waddr   = qaddr(r_phys[own][sidx], tail);
                    we[own] = r_fill[own][sidx] < FW'(ORDERS_PER_LEVEL);
                end else if (ins) begin
                    waddr   = qaddr(r_phys[own][uidx], '0);
                    we[own] = r_used[own] < UW'(MAX_LEVELS);
                end
            end
            default: begin
            end
        endcase
    end

    lobm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ask_ram (
        .i_clk   (i_clk),
        .i_we    (we[lobm_pkg::SIDE_ASK]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr[lobm_pkg::SIDE_ASK]),
        .o_rdata (rdata[lobm_pkg::SIDE_ASK])
    );

    lobm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (we[lobm_pkg::SIDE_BID]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr[lobm_pkg::SIDE_BID]),
        .o_rdata (rdata[lobm_pkg::SIDE_BID])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_state   <= S_IDLE;
            r_next_id <= 32'd1;
            for (int s = 0; s < 2; s++) begin
                r_used[s] <= '0;
                for (int i = 0; i < MAX_LEVELS; i++) begin
                    r_fill[s][i] <= '0;
                    r_phys[s][i] <= LW'(i);
                end
            end
        end else begin
            r_valid <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_buy     <= i_order.is_buy;
                        r_lim     <= i_order.limit_price;
                        r_rem     <= i_order.quantity;
                        r_id      <= r_next_id;
                        r_next_id <= r_next_id + 32'd1;
                        r_filled  <= '0;
                        r_rested  <= '0;
                        r_status  <= lobm_pkg::ST_OK;
                        r_state   <= (i_order.quantity == 32'd0) ? S_FIN : S_MCHK;
                    end
                end
                S_MCHK: begin
                    r_idx <= '0;
                    if (can_match) begin
                        r_state <= S_MRD;
                    end else if (r_rem == 32'd0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_MRD: begin
                    r_rem    <= r_rem - take;
                    r_filled <= r_filled + take;
                    if (pop) begin
                        if (r_fill[opp][0] == FW'(1)) begin
                            for (int i = 0; i < MAX_LEVELS - 1; i++) begin
                                r_price[opp][i] <= r_price[opp][i+1];
                                r_fill[opp][i]  <= r_fill[opp][i+1];
                                r_head[opp][i]  <= r_head[opp][i+1];
                                r_phys[opp][i]  <= r_phys[opp][i+1];
                            end
                            r_phys[opp][MAX_LEVELS-1] <= r_phys[opp][0];
                            r_used[opp] <= r_used[opp] - UW'(1);
                        end else begin
                            r_head[opp][0] <= nhead;
                            r_fill[opp][0] <= r_fill[opp][0] - FW'(1);
                        end
                    end
                    r_state <= S_MCHK;
                end
                S_SRCH: begin
                    if (eq) begin
                        if (r_fill[own][sidx] < FW'(ORDERS_PER_LEVEL)) begin
                            r_fill[own][sidx] <= r_fill[own][sidx] + FW'(1);
                            r_rested <= r_rem;
                        end else begin
                            r_status <= lobm_pkg::ST_DROPPED;
                        end
                        r_state <= S_FIN;
                    end else if (ins) begin
                        if (r_used[own] < UW'(MAX_LEVELS)) begin
                            for (int i = 1; i < MAX_LEVELS; i++) begin
                                if (LW'(i) > pos && UW'(i) <= r_used[own]) begin
                                    r_price[own][i] <= r_price[own][i-1];
                                    r_fill[own][i]  <= r_fill[own][i-1];
                                    r_head[own][i]  <= r_head[own][i-1];
                                    r_phys[own][i]  <= r_phys[own][i-1];
                                end
                            end
                            r_price[own][pos] <= r_lim;
                            r_fill[own][pos]  <= FW'(1);
                            r_head[own][pos]  <= '0;
                            r_phys[own][pos]  <= r_phys[own][uidx];
                            r_used[own]       <= r_used[own] + UW'(1);
                            r_rested          <= r_rem;
                        end else begin
                            r_status <= lobm_pkg::ST_DROPPED;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + UW'(1);
                    end
                end
                S_FIN: begin
                    r_out.order_id   <= r_id;
                    r_out.filled_qty <= r_filled;
                    r_out.rested_qty <= r_rested;
                    r_out.status     <= r_status;
                    r_out.best_bid   <= (r_used[lobm_pkg::SIDE_BID] != '0)
                                        ? r_price[lobm_pkg::SIDE_BID][0] : 32'd0;
                    r_out.best_ask   <= (r_used[lobm_pkg::SIDE_ASK] != '0)
                                        ? r_price[lobm_pkg::SIDE_ASK][0] : 32'd0;
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

>>> hw/rtl/lobm_ram.sv
module lobm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/limit_order_book_matcher_tb.sv
module limit_order_book_matcher_tb;

    localparam int NUM_LEVELS = 16;
    localparam int NUM_SLOTS  = 16;
    localparam int WATCHDOG   = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    lobm_pkg::t_order_in  i_order = '0;
    logic                 busy;
    logic                 o_valid;
    lobm_pkg::t_order_out o_result;

    limit_order_book_matcher #(
        .MAX_LEVELS(NUM_LEVELS),
        .ORDERS_PER_LEVEL(NUM_SLOTS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_order(i_order),
        .busy(busy),
        .o_valid(o_valid),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // The book as the matcher should hold it; index 0 is the bid side.
    logic [31:0] lvl_price [2][NUM_LEVELS];
    logic [31:0] lvl_sizes [2][NUM_LEVELS][NUM_SLOTS];
    int          lvl_fill  [2][NUM_LEVELS];
    int          lvl_used  [2];
    logic [31:0] id_next;

    lobm_pkg::t_order_in  order_queue[$];
    lobm_pkg::t_order_out fill_queue[$];
    int          errors = 0;
    int          sender_idle = 0;
    int          quiet_cycles = 0;

    function automatic int side_ix(logic buy);
        return (buy == lobm_pkg::SIDE_BID) ? 0 : 1;
    endfunction

    function automatic void drop_best(int s);
        for (int i = 0; i + 1 < lvl_used[s]; i++) begin
            lvl_price[s][i] = lvl_price[s][i+1];
            lvl_fill[s][i]  = lvl_fill[s][i+1];
            lvl_sizes[s][i] = lvl_sizes[s][i+1];
        end
        lvl_used[s]--;
    endfunction

    function automatic lobm_pkg::t_order_out trade_order(lobm_pkg::t_order_in o);
        lobm_pkg::t_order_out r;
        logic [31:0] rem;
        logic [31:0] take;
        int opp;
        int own;
        int pos;
        bit found;
        r = '0;
        r.order_id = id_next;
        id_next++;
        rem = o.quantity;
        own = side_ix(o.is_buy);
        opp = 1 - own;
        while (rem > 0 && lvl_used[opp] > 0) begin
            if (o.is_buy == lobm_pkg::SIDE_BID && o.limit_price < lvl_price[opp][0]) break;
            if (o.is_buy == lobm_pkg::SIDE_ASK && o.limit_price > lvl_price[opp][0]) break;
            while (rem > 0 && lvl_fill[opp][0] > 0) begin
                take = (lvl_sizes[opp][0][0] < rem) ? lvl_sizes[opp][0][0] : rem;
                rem -= take;
                lvl_sizes[opp][0][0] -= take;
                r.filled_qty += take;
                if (lvl_sizes[opp][0][0] == 0) begin
                    for (int k = 0; k < NUM_SLOTS - 1; k++)
                        lvl_sizes[opp][0][k] = lvl_sizes[opp][0][k+1];
                    lvl_fill[opp][0]--;
                end
            end
            if (lvl_fill[opp][0] == 0) drop_best(opp);
        end
        r.status = lobm_pkg::ST_OK;
        if (rem > 0) begin
            found = 1'b0;
            for (int i = 0; i < lvl_used[own] && !found; i++) begin
                if (lvl_price[own][i] == o.limit_price) begin
                    found = 1'b1;
                    if (lvl_fill[own][i] >= NUM_SLOTS) begin
                        r.status = lobm_pkg::ST_DROPPED;
                    end else begin
                        lvl_sizes[own][i][lvl_fill[own][i]] = rem;
                        lvl_fill[own][i]++;
                        r.rested_qty = rem;
                    end
                end
            end
            if (!found) begin
                if (lvl_used[own] >= NUM_LEVELS) begin
                    r.status = lobm_pkg::ST_DROPPED;
                end else begin
                    pos = lvl_used[own];
                    for (int i = lvl_used[own] - 1; i >= 0; i--) begin
                        if (own == 0 ? (lvl_price[own][i] < o.limit_price)
                                     : (lvl_price[own][i] > o.limit_price)) pos = i;
                    end
                    for (int i = lvl_used[own]; i > pos; i--) begin
                        lvl_price[own][i] = lvl_price[own][i-1];
                        lvl_fill[own][i]  = lvl_fill[own][i-1];
                        lvl_sizes[own][i] = lvl_sizes[own][i-1];
                    end
                    lvl_price[own][pos] = o.limit_price;
                    lvl_fill[own][pos] = 1;
                    lvl_sizes[own][pos][0] = rem;
                    lvl_used[own]++;
                    r.rested_qty = rem;
                end
            end
        end
        r.best_bid = (lvl_used[0] > 0) ? lvl_price[0][0] : 32'd0;
        r.best_ask = (lvl_used[1] > 0) ? lvl_price[1][0] : 32'd0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic lobm_pkg::t_order_in mk(logic buy, logic [31:0] px,
                                               logic [31:0] qty);
        lobm_pkg::t_order_in o;
        o.is_buy = buy;
        o.limit_price = px;
        o.quantity = qty;
        return o;
    endfunction

    function automatic void add_order(lobm_pkg::t_order_in o);
        order_queue = {order_queue, o};
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(1, 50);
        endcase
    endfunction

    // Driver: start stays high across back-to-back beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(start && busy)) begin
                if (start) void'(order_queue.pop_front());
                if (order_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
                    start   <= 1'b1;
                    i_order <= order_queue[0];
                end else begin
                    start   <= 1'b0;
                    i_order <= {1'($urandom), 32'($urandom), 32'($urandom)};
                end
            end
        end
    end

    // The beat is accepted at this edge, so predict from what is presented now.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            lobm_pkg::t_order_out p;
            p = trade_order(i_order);
            fill_queue = {fill_queue, p};
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            lobm_pkg::t_order_out w;
            if (fill_queue.size() == 0) begin
                report_mismatch("unexpected beat", o_result.order_id, 32'd0);
            end else begin
                w = fill_queue.pop_front();
                if (o_result.order_id !== w.order_id)
                    report_mismatch("order_id", o_result.order_id, w.order_id);
                if (o_result.filled_qty !== w.filled_qty)
                    report_mismatch("filled_qty", o_result.filled_qty, w.filled_qty);
                if (o_result.rested_qty !== w.rested_qty)
                    report_mismatch("rested_qty", o_result.rested_qty, w.rested_qty);
                if (o_result.status !== w.status)
                    report_mismatch("status", 32'(o_result.status), 32'(w.status));
                if (o_result.best_bid !== w.best_bid)
                    report_mismatch("best_bid", o_result.best_bid, w.best_bid);
                if (o_result.best_ask !== w.best_ask)
                    report_mismatch("best_ask", o_result.best_ask, w.best_ask);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL limit_order_book_matcher");
            $finish;
        end
    end

    initial begin
        int remaining;
        int phase_len;
        logic [31:0] base;
        lvl_used = '{0, 0};
        id_next = 32'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty book, zero size, price extremes, full matches.
        add_order(mk(lobm_pkg::SIDE_BID, 32'd100, 32'd0));
        add_order(mk(lobm_pkg::SIDE_BID, 32'd0, 32'd5));
        add_order(mk(lobm_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_order(mk(lobm_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
        add_order(mk(lobm_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'd7));
        add_order(mk(lobm_pkg::SIDE_ASK, 32'd0, 32'd20));
        add_order(mk(lobm_pkg::SIDE_BID, 32'd50, 32'd3));
        add_order(mk(lobm_pkg::SIDE_BID, 32'd50, 32'd4));
        add_order(mk(lobm_pkg::SIDE_ASK, 32'd40, 32'd5));
        add_order(mk(lobm_pkg::SIDE_ASK, 32'd60, 32'd0));
        add_order(mk(lobm_pkg::SIDE_ASK, 32'd50, 32'd10));
        // Fill one level's FIFO past its depth, then the level table.
        repeat (NUM_SLOTS + 1) add_order(mk(lobm_pkg::SIDE_BID, 32'd10, 32'd1));
        for (int i = 0; i < NUM_LEVELS + 1; i++)
            add_order(mk(lobm_pkg::SIDE_BID, 32'd11 + 32'(i), 32'd2));
        add_order(mk(lobm_pkg::SIDE_ASK, 32'd0, 32'hFFFF_FFFF));

        remaining = 600;
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle = (ph == 1) ? 80 : (ph == 3) ? 10 : 0;
            phase_len = remaining / (4 - ph);
            remaining -= phase_len;
            base = (ph == 2) ? 32'hFFFF_FFE0 : 32'd1000;
            for (int n = 0; n < phase_len; n++) begin
                case ($urandom_range(0, 19))
                    0: add_order(mk(1'($urandom), $urandom, $urandom));
                    1: add_order(mk(1'($urandom), base + $urandom_range(0, 3),
                                    rand_qty()));
                    default: add_order(mk(1'($urandom),
                                          base + $urandom_range(0, 24),
                                          rand_qty()));
                endcase
            end
            wait (order_queue.size() == 0 && !start);
        end
        // Reach id wrap is impractical; the watchdog-bounded run ends here.
        wait (fill_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && fill_queue.size() == 0) begin
            $display("PASS limit_order_book_matcher");
        end else begin
            $display("FAIL limit_order_book_matcher");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_ram.sv
hw/rtl/limit_order_book_matcher.sv
tb/limit_order_book_matcher_tb.sv
